FILE: rtl/miau_pkg.sv
// ----------------------------------------------------------------------------
// miau_pkg
// Shared constants, command codes and interface types of the multiword
// integer arithmetic unit.
// ----------------------------------------------------------------------------
package miau_pkg;

    localparam int WORDS  = 16;
    localparam int WORD_W = 32;
    localparam int BITS   = WORD_W * WORDS;
    localparam int CNT_W  = $clog2(WORDS + 1);
    localparam int IDX_W  = $clog2(WORDS);
    localparam int BCNT_W = $clog2(BITS);

    // operation codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_GCD = 3'd4;
    localparam logic [2:0] OP_LCM = 3'd5;
    localparam logic [2:0] OP_POW = 3'd6;
    localparam logic [2:0] OP_CMP = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;

    // order codes
    localparam logic [1:0] ORD_EQ = 2'd0;
    localparam logic [1:0] ORD_LT = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    // datapath commands
    localparam logic [4:0] C_NONE      = 5'd0;
    localparam logic [4:0] C_START     = 5'd1;
    localparam logic [4:0] C_ADD       = 5'd2;
    localparam logic [4:0] C_SUB       = 5'd3;
    localparam logic [4:0] C_ZERO_DIV0 = 5'd4;
    localparam logic [4:0] C_CMPRES    = 5'd5;
    localparam logic [4:0] C_MUL_AB    = 5'd6;
    localparam logic [4:0] C_MUL_UV    = 5'd7;
    localparam logic [4:0] C_MUL_VV    = 5'd8;
    localparam logic [4:0] C_MUL_STEP  = 5'd9;
    localparam logic [4:0] C_MP2ACC    = 5'd10;
    localparam logic [4:0] C_MP2U      = 5'd11;
    localparam logic [4:0] C_MP2V      = 5'd12;
    localparam logic [4:0] C_DIV_AB    = 5'd13;
    localparam logic [4:0] C_DIV_UV    = 5'd14;
    localparam logic [4:0] C_DIV_PG    = 5'd15;
    localparam logic [4:0] C_DIV_STEP  = 5'd16;
    localparam logic [4:0] C_DIVRES    = 5'd17;
    localparam logic [4:0] C_DIVQ_ACC  = 5'd18;
    localparam logic [4:0] C_GCD_INIT  = 5'd19;
    localparam logic [4:0] C_GCD_NEXT  = 5'd20;
    localparam logic [4:0] C_U2ACC     = 5'd21;
    localparam logic [4:0] C_POW_INIT  = 5'd22;
    localparam logic [4:0] C_OUT_SHIFT = 5'd23;

    typedef struct packed {
        logic [4:0] code;
        logic       load;
    } cmd_t;

    typedef struct packed {
        logic b_zero;
        logic u_zero;
        logic v_zero;
        logic e_zero;
        logic e_lsb;
        logic my_zero;
        logic div_last;
        logic out_last;
    } sts_t;

endpackage

FILE: rtl/multiword_integer_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// multiword_integer_arithmetic_unit_top
// Multiword unsigned arithmetic on two 512-bit operands (16 words of 32).
// ----------------------------------------------------------------------------
// Operands load one word pair per item, least significant first; the item
// with last_in set starts the operation given on it. Missing words read as
// zero; pairs beyond 16 are dropped. Items are taken only while idle. After
// last_in the block is busy: multiply takes one shift-add step per multiplier
// bit position, stopping once the remaining multiplier is zero, divmod one
// restoring step per bit, gcd one divide per Euclid step, lcm a gcd plus one
// multiply plus one divide, and power up to two multiplies per exponent bit,
// all on the single shared 512-bit shift-add/restoring-divide datapath. The
// result then streams out one word per accepted item (16 words, or one for
// compare), during which no input item is taken. Results wrap modulo 2^512;
// a subtract that would underflow returns a unchanged with status under.
// ----------------------------------------------------------------------------
module multiword_integer_arithmetic_unit_top
    import miau_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_operation,
    input  logic [WORD_W-1:0]   s_a_word,
    input  logic [WORD_W-1:0]   s_b_word,
    input  logic                s_last_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [WORD_W-1:0]   m_result_word,
    output logic [WORD_W-1:0]   m_second_word,
    output logic [1:0]          m_status,
    output logic [1:0]          m_order,
    output logic                m_last_out
);

    cmd_t cmd;   // controller to datapath
    sts_t sts;   // datapath flags back to the controller

    miau_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_last_in   (s_last_in),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    miau_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_a_word      (s_a_word),
        .s_b_word      (s_b_word),
        .sts           (sts),
        .m_result_word (m_result_word),
        .m_second_word (m_second_word),
        .m_status      (m_status),
        .m_order       (m_order),
        .m_last_out    (m_last_out)
    );

endmodule

FILE: rtl/miau_datapath.sv
// ----------------------------------------------------------------------------
// miau_datapath
// Operand store, 512-bit work registers, shift-add multiplier, restoring
// divider and result word streaming.
// ----------------------------------------------------------------------------
module miau_datapath
    import miau_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    input  logic [WORD_W-1:0]   s_a_word,
    input  logic [WORD_W-1:0]   s_b_word,
    output sts_t                sts,
    output logic [WORD_W-1:0]   m_result_word,
    output logic [WORD_W-1:0]   m_second_word,
    output logic [1:0]          m_status,
    output logic [1:0]          m_order,
    output logic                m_last_out
);

    logic [CNT_W-1:0]  count_reg;
    logic [BITS-1:0]   opa_reg, opb_reg;
    logic [BITS-1:0]   acc_reg, rem_reg;
    logic [BITS-1:0]   u_reg, v_reg, e_reg;
    logic [BITS-1:0]   mx_reg, my_reg, mp_reg;
    logic [BITS-1:0]   dq_reg, dv_reg, rr_reg;
    logic [BCNT_W-1:0] dcnt_reg;
    logic [IDX_W-1:0]  ocnt_reg;
    logic [1:0]        st_reg, ord_reg;
    logic              one_word_reg;

    logic [BITS-1:0]   ma, mb;
    logic [BITS:0]     shifted, trial;
    logic              take;

    // words not loaded since the last operation read as zero
    always_comb begin
        for (int i = 0; i < WORDS; i++) begin
            ma[i*WORD_W +: WORD_W] = (CNT_W'(i) < count_reg) ? opa_reg[i*WORD_W +: WORD_W] : '0;
            mb[i*WORD_W +: WORD_W] = (CNT_W'(i) < count_reg) ? opb_reg[i*WORD_W +: WORD_W] : '0;
        end
    end

    // restoring division step
    assign shifted = {rr_reg, dq_reg[BITS-1]};
    assign trial   = shifted - {1'b0, dv_reg};
    assign take    = (shifted >= {1'b0, dv_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            if (cmd.load && count_reg < CNT_W'(WORDS)) begin
                for (int i = 0; i < WORDS; i++) begin
                    if (count_reg == CNT_W'(i)) begin
                        opa_reg[i*WORD_W +: WORD_W] <= s_a_word;
                        opb_reg[i*WORD_W +: WORD_W] <= s_b_word;
                    end
                end
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.code == C_START) begin
                count_reg <= '0;
                opa_reg   <= ma;
                opb_reg   <= mb;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.code)
            C_START: begin
                ord_reg <= (ma == mb) ? ORD_EQ : ((ma < mb) ? ORD_LT : ORD_GT);
            end
            C_ADD: begin
                acc_reg <= opa_reg + opb_reg;
                rem_reg <= '0;
                st_reg <= ST_OK;
                one_word_reg <= 1'b0;
                ocnt_reg <= '0;
            end
            C_SUB: begin
                if (opa_reg < opb_reg) begin
                    acc_reg <= opa_reg;
                    st_reg <= ST_UNDER;
                end else begin
                    acc_reg <= opa_reg - opb_reg;
                    st_reg <= ST_OK;
                end
                rem_reg <= '0;
                one_word_reg <= 1'b0;
                ocnt_reg <= '0;
            end
            C_ZERO_DIV0: begin
                acc_reg <= '0;
                rem_reg <= '0;
                st_reg <= ST_DIV0;
                one_word_reg <= 1'b0;
                ocnt_reg <= '0;
            end
            C_CMPRES: begin
                acc_reg <= '0;
                rem_reg <= '0;
                st_reg <= ST_OK;
                one_word_reg <= 1'b1;
                ocnt_reg <= '0;
            end
            C_MUL_AB: begin
                mx_reg <= opa_reg;
                my_reg <= opb_reg;
                mp_reg <= '0;
            end
            C_MUL_UV: begin
                mx_reg <= u_reg;
                my_reg <= v_reg;
                mp_reg <= '0;
            end
            C_MUL_VV: begin
                mx_reg <= v_reg;
                my_reg <= v_reg;
                mp_reg <= '0;
            end
            C_MUL_STEP: begin
                if (my_reg[0]) begin
                    mp_reg <= mp_reg + mx_reg;
                end
                mx_reg <= {mx_reg[BITS-2:0], 1'b0};
                my_reg <= {1'b0, my_reg[BITS-1:1]};
            end
            C_MP2ACC: begin
                acc_reg <= mp_reg;
                rem_reg <= '0;
                st_reg <= ST_OK;
                one_word_reg <= 1'b0;
                ocnt_reg <= '0;
            end
            C_MP2U: begin
                u_reg <= mp_reg;
            end
            C_MP2V: begin
                v_reg <= mp_reg;
                e_reg <= {1'b0, e_reg[BITS-1:1]};
            end
            C_DIV_AB: begin
                dq_reg <= opa_reg;
                dv_reg <= opb_reg;
                rr_reg <= '0;
                dcnt_reg <= '0;
            end
            C_DIV_UV: begin
                dq_reg <= u_reg;
                dv_reg <= v_reg;
                rr_reg <= '0;
                dcnt_reg <= '0;
            end
            C_DIV_PG: begin
                dq_reg <= mp_reg;
                dv_reg <= u_reg;
                rr_reg <= '0;
                dcnt_reg <= '0;
            end
            C_DIV_STEP: begin
                rr_reg <= take ? trial[BITS-1:0] : shifted[BITS-1:0];
                dq_reg <= {dq_reg[BITS-2:0], take};
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            C_DIVRES: begin
                acc_reg <= dq_reg;
                rem_reg <= rr_reg;
                st_reg <= ST_OK;
                one_word_reg <= 1'b0;
                ocnt_reg <= '0;
            end
            C_DIVQ_ACC: begin
                acc_reg <= dq_reg;
                rem_reg <= '0;
                st_reg <= ST_OK;
                one_word_reg <= 1'b0;
                ocnt_reg <= '0;
            end
            C_GCD_INIT: begin
                u_reg <= opa_reg;
                v_reg <= opb_reg;
            end
            C_GCD_NEXT: begin
                u_reg <= v_reg;
                v_reg <= rr_reg;
            end
            C_U2ACC: begin
                acc_reg <= u_reg;
                rem_reg <= '0;
                st_reg <= ST_OK;
                one_word_reg <= 1'b0;
                ocnt_reg <= '0;
            end
            C_POW_INIT: begin
                u_reg <= BITS'(1);
                v_reg <= opa_reg;
                e_reg <= opb_reg;
            end
            C_OUT_SHIFT: begin
                acc_reg <= {{WORD_W{1'b0}}, acc_reg[BITS-1:WORD_W]};
                rem_reg <= {{WORD_W{1'b0}}, rem_reg[BITS-1:WORD_W]};
                ocnt_reg <= ocnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign sts.b_zero   = (opb_reg == '0);
    assign sts.u_zero   = (u_reg == '0);
    assign sts.v_zero   = (v_reg == '0);
    assign sts.e_zero   = (e_reg == '0);
    assign sts.e_lsb    = e_reg[0];
    assign sts.my_zero  = (my_reg == '0);
    assign sts.div_last = (dcnt_reg == BCNT_W'(BITS - 1));
    assign sts.out_last = one_word_reg || (ocnt_reg == IDX_W'(WORDS - 1));

    assign m_result_word = acc_reg[WORD_W-1:0];
    assign m_second_word = rem_reg[WORD_W-1:0];
    assign m_status      = st_reg;
    assign m_order       = ord_reg;
    assign m_last_out    = sts.out_last;

endmodule

FILE: rtl/miau_ctrl.sv
// ----------------------------------------------------------------------------
// miau_ctrl
// Sequencer: loads items, runs add, sub and compare directly and the rest
// as chains of multiply and divide passes, then streams the result words.
// ----------------------------------------------------------------------------
module miau_ctrl
    import miau_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [2:0] s_operation,
    input  logic       s_last_in,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_START   = 4'd1;
    localparam logic [3:0] S_EXEC    = 4'd2;
    localparam logic [3:0] S_MUL     = 4'd3;
    localparam logic [3:0] S_DIV     = 4'd4;
    localparam logic [3:0] S_DIV_END = 4'd5;
    localparam logic [3:0] S_GCD     = 4'd6;
    localparam logic [3:0] S_POW     = 4'd7;
    localparam logic [3:0] S_POW_SQ  = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    // what a multiply or divide pass feeds into
    localparam logic [2:0] P_MUL    = 3'd0;
    localparam logic [2:0] P_LCM    = 3'd1;
    localparam logic [2:0] P_POWU   = 3'd2;
    localparam logic [2:0] P_POWV   = 3'd3;
    localparam logic [2:0] P_DIVMOD = 3'd4;
    localparam logic [2:0] P_GCD    = 3'd5;
    localparam logic [2:0] P_LCMDIV = 3'd6;

    logic [3:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] op_reg, op_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= P_MUL;
            op_reg    <= OP_ADD;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        op_next    = op_reg;
        cmd.code   = C_NONE;
        cmd.load   = s_valid && s_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_last_in) begin
                    op_next    = s_operation;
                    state_next = S_START;
                end
            end
            S_START: begin
                cmd.code   = C_START;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                case (op_reg)
                    OP_ADD: begin
                        cmd.code   = C_ADD;
                        state_next = S_OUT;
                    end
                    OP_SUB: begin
                        cmd.code   = C_SUB;
                        state_next = S_OUT;
                    end
                    OP_MUL: begin
                        cmd.code   = C_MUL_AB;
                        phase_next = P_MUL;
                        state_next = S_MUL;
                    end
                    OP_DIV: begin
                        if (sts.b_zero) begin
                            cmd.code   = C_ZERO_DIV0;
                            state_next = S_OUT;
                        end else begin
                            cmd.code   = C_DIV_AB;
                            phase_next = P_DIVMOD;
                            state_next = S_DIV;
                        end
                    end
                    OP_GCD, OP_LCM: begin
                        cmd.code   = C_GCD_INIT;
                        state_next = S_GCD;
                    end
                    OP_POW: begin
                        cmd.code   = C_POW_INIT;
                        state_next = S_POW;
                    end
                    default: begin
                        cmd.code   = C_CMPRES;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_MUL: begin
                if (!sts.my_zero) begin
                    cmd.code = C_MUL_STEP;
                end else begin
                    case (phase_reg)
                        P_LCM: begin
                            cmd.code   = C_DIV_PG;
                            phase_next = P_LCMDIV;
                            state_next = S_DIV;
                        end
                        P_POWU: begin
                            cmd.code   = C_MP2U;
                            state_next = S_POW_SQ;
                        end
                        P_POWV: begin
                            cmd.code   = C_MP2V;
                            state_next = S_POW;
                        end
                        default: begin
                            cmd.code   = C_MP2ACC;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_DIV: begin
                cmd.code = C_DIV_STEP;
                if (sts.div_last) begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END: begin
                case (phase_reg)
                    P_GCD: begin
                        cmd.code   = C_GCD_NEXT;
                        state_next = S_GCD;
                    end
                    P_LCMDIV: begin
                        cmd.code   = C_DIVQ_ACC;
                        state_next = S_OUT;
                    end
                    default: begin
                        cmd.code   = C_DIVRES;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_GCD: begin
                if (!sts.v_zero) begin
                    cmd.code   = C_DIV_UV;
                    phase_next = P_GCD;
                    state_next = S_DIV;
                end else if (op_reg == OP_GCD) begin
                    cmd.code   = C_U2ACC;
                    state_next = S_OUT;
                end else if (sts.u_zero) begin
                    cmd.code   = C_ZERO_DIV0;
                    state_next = S_OUT;
                end else begin
                    cmd.code   = C_MUL_AB;
                    phase_next = P_LCM;
                    state_next = S_MUL;
                end
            end
            S_POW: begin
                if (sts.e_zero) begin
                    cmd.code   = C_U2ACC;
                    state_next = S_OUT;
                end else if (sts.e_lsb) begin
                    cmd.code   = C_MUL_UV;
                    phase_next = P_POWU;
                    state_next = S_MUL;
                end else begin
                    cmd.code   = C_MUL_VV;
                    phase_next = P_POWV;
                    state_next = S_MUL;
                end
            end
            S_POW_SQ: begin
                cmd.code   = C_MUL_VV;
                phase_next = P_POWV;
                state_next = S_MUL;
            end
            S_OUT: begin
                if (m_ready) begin
                    cmd.code = C_OUT_SHIFT;
                    if (sts.out_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/miau_checker.sv
// ----------------------------------------------------------------------------
// miau_checker
// Port-level checks of the arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module miau_checker
    import miau_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [WORD_W-1:0]   m_result_word,
    input logic [WORD_W-1:0]   m_second_word,
    input logic [1:0]          m_status,
    input logic [1:0]          m_order
);

    // input is never taken while a result is on offer
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while result pending");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_word))
        else $error("result item dropped or changed while stalled");

    a_div0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DIV0 |-> m_result_word == '0 && m_second_word == '0)
        else $error("division by zero gave non-zero words");

    a_under_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_UNDER |-> m_order == ORD_LT)
        else $error("underflow flagged without a below b");

    a_div0_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DIV0 |-> m_order != ORD_LT)
        else $error("division by zero flagged with a below b");

endmodule

bind multiword_integer_arithmetic_unit_top miau_checker u_chk (.*);

FILE: verif/tb_multiword_integer_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiword_integer_arithmetic_unit_top
// Self-checking bench for the multiword arithmetic unit. A directed table of
// items comes first, then random operand sequences. Every accepted item
// goes into a 512-bit model of the unit. Every result item is checked field
// by field against the oldest predicted word. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_multiword_integer_arithmetic_unit_top;
    import miau_pkg::*;

    typedef logic [BITS-1:0] wide_t;

    typedef struct {
        logic [WORD_W-1:0] res;
        logic [WORD_W-1:0] sec;
        logic [1:0]        st;
        logic [1:0]        ord;
        logic              lst;
    } word_exp_t;

    typedef struct {
        logic [2:0]        op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              last;
        logic              chk;     // first word and status typed in below
        logic [WORD_W-1:0] w0;
        logic [1:0]        st;
    } row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [2:0]        s_operation = OP_ADD;
    logic [WORD_W-1:0] s_a_word = '0;
    logic [WORD_W-1:0] s_b_word = '0;
    logic              s_last_in = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [WORD_W-1:0] m_result_word;
    logic [WORD_W-1:0] m_second_word;
    logic [1:0]        m_status;
    logic [1:0]        m_order;
    logic              m_last_out;

    // model state: operands as loaded so far
    wide_t       opnd_a;
    wide_t       opnd_b;
    int unsigned words_held;

    word_exp_t   pending_words[$];
    logic [WORD_W-1:0] first_word_pred;
    logic [1:0]        status_pred;

    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    bit          calm = 1'b0;      // no idling on either side while set

    row_t        rows[$];

    multiword_integer_arithmetic_unit_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_a_word      (s_a_word),
        .s_b_word      (s_b_word),
        .s_last_in     (s_last_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_word (m_result_word),
        .m_second_word (m_second_word),
        .m_status      (m_status),
        .m_order       (m_order),
        .m_last_out    (m_last_out)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- model
    function automatic wide_t gcd_of(wide_t x, wide_t y);
        wide_t u, v, t;
        u = x;
        v = y;
        while (v != '0) begin
            t = u % v;
            u = v;
            v = t;
        end
        return u;
    endfunction

    function automatic wide_t power_of(wide_t x, wide_t e);
        wide_t acc, base;
        acc = wide_t'(1);
        base = x;
        for (int i = 0; i < BITS; i++) begin
            if (e[i])
                acc = acc * base;
            base = base * base;
        end
        return acc;
    endfunction

    // Takes one accepted item; on last_in queues the words of the answer.
    task automatic absorb_item(logic [2:0] op, logic [WORD_W-1:0] aw,
                               logic [WORD_W-1:0] bw, logic last);
        wide_t main_r, rem_r, g;
        logic [1:0] st, ord;
        int n;
        word_exp_t w;
        if (words_held < WORDS) begin
            opnd_a[words_held*WORD_W +: WORD_W] = aw;
            opnd_b[words_held*WORD_W +: WORD_W] = bw;
            words_held++;
        end
        if (!last)
            return;
        ord = (opnd_a == opnd_b) ? ORD_EQ : ((opnd_a < opnd_b) ? ORD_LT : ORD_GT);
        main_r = '0;
        rem_r = '0;
        st = ST_OK;
        n = WORDS;
        case (op)
            OP_ADD: main_r = opnd_a + opnd_b;
            OP_SUB: begin
                if (opnd_b > opnd_a) begin
                    main_r = opnd_a;
                    st = ST_UNDER;
                end else begin
                    main_r = opnd_a - opnd_b;
                end
            end
            OP_MUL: main_r = opnd_a * opnd_b;
            OP_DIV: begin
                if (opnd_b == '0) begin
                    st = ST_DIV0;
                end else begin
                    main_r = opnd_a / opnd_b;
                    rem_r = opnd_a % opnd_b;
                end
            end
            OP_GCD: main_r = gcd_of(opnd_a, opnd_b);
            OP_LCM: begin
                g = gcd_of(opnd_a, opnd_b);
                if (g == '0)
                    st = ST_DIV0;
                else
                    main_r = wide_t'(opnd_a * opnd_b) / g;
            end
            OP_POW: main_r = power_of(opnd_a, opnd_b);
            default: n = 1;     // compare: one word, data zero
        endcase
        for (int k = 0; k < n; k++) begin
            w.res = main_r[k*WORD_W +: WORD_W];
            w.sec = rem_r[k*WORD_W +: WORD_W];
            w.st  = st;
            w.ord = ord;
            w.lst = (k == n - 1);
            pending_words.push_back(w);
        end
        first_word_pred = main_r[WORD_W-1:0];
        status_pred = st;
        opnd_a = '0;
        opnd_b = '0;
        words_held = 0;
    endtask

    // ------------------------------------------------------- monitor/checker
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                absorb_item(s_operation, s_a_word, s_b_word, s_last_in);
            if (m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: word %h", m_result_word);
                end else begin
                    word_exp_t w;
                    w = pending_words.pop_front();
                    if (w.res !== m_result_word || w.sec !== m_second_word ||
                        w.st !== m_status || w.ord !== m_order ||
                        w.lst !== m_last_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h %h st%0d ord%0d l%0d, got %h %h st%0d ord%0d l%0d",
                                     w.res, w.sec, w.st, w.ord, w.lst, m_result_word,
                                     m_second_word, m_status, m_order, m_last_out);
                    end
                end
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk)
        m_ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 38);

    // ----------------------------------------------------------------- driver
    task automatic send_item(logic [2:0] op, logic [WORD_W-1:0] aw,
                             logic [WORD_W-1:0] bw, logic last);
        if (!calm) begin
            while ($urandom_range(0, 99) < 38) begin
                s_valid = 1'b0;
                @(negedge aclk);
            end
        end
        s_valid = 1'b1;
        s_operation = op;
        s_a_word = aw;
        s_b_word = bw;
        s_last_in = last;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        items_sent++;
        calm = (items_sent >= 150 && items_sent < 220);
    endtask

    task automatic add_row(logic [2:0] op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                           logic last, logic chk, logic [WORD_W-1:0] w0, logic [1:0] st);
        row_t r;
        r = '{op, a, b, last, chk, w0, st};
        rows.push_back(r);
    endtask

    function automatic logic [WORD_W-1:0] pick_word(int unsigned lim);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, lim);
            default: return $urandom();
        endcase
    endfunction

    // One operation with random operands; gcd and lcm stay short since each
    // Euclid step costs a whole bit-serial divide.
    task automatic random_operation();
        logic [2:0] op;
        int len;
        logic [WORD_W-1:0] aw, bw;
        bit same;
        op = 3'($urandom_range(0, 7));
        if (op == OP_GCD || op == OP_LCM)
            len = $urandom_range(1, 3);
        else if ($urandom_range(0, 7) == 0)
            len = $urandom_range(WORDS + 1, WORDS + 3);   // surplus pairs dropped
        else
            len = $urandom_range(1, WORDS);
        same = (op == OP_CMP || op == OP_SUB || op == OP_DIV) && $urandom_range(0, 3) == 0;
        for (int i = 0; i < len; i++) begin
            aw = pick_word(1000);
            bw = same ? aw : pick_word(1000);
            if (op == OP_POW) begin
                if (i > 0)
                    bw = '0;
                else if ($urandom_range(0, 7) != 0)
                    bw = $urandom_range(0, 40);
            end
            // operation field is only read on the last pair: fill it with noise
            send_item((i == len - 1) ? op : 3'($urandom_range(0, 7)), aw, bw,
                      i == len - 1);
        end
    endtask

    // ---------------------------------------------------------------- stimulus
    initial begin
        row_t r;
        opnd_a = '0;
        opnd_b = '0;
        words_held = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        add_row(OP_CMP, 0, 0, 1, 1, 0, ST_OK);                  // fresh compare
        add_row(OP_ADD, '1, 1, 1, 1, 0, ST_OK);                 // carry out of word 0
        add_row(OP_SUB, 1, 2, 1, 1, 1, ST_UNDER);               // underflow
        add_row(OP_SUB, 9, 9, 1, 1, 0, ST_OK);
        add_row(OP_DIV, 5, 0, 1, 1, 0, ST_DIV0);                // divide by zero
        add_row(OP_LCM, 0, 0, 1, 1, 0, ST_DIV0);                // lcm of zeros
        add_row(OP_GCD, 0, 12, 1, 1, 12, ST_OK);                // gcd with zero
        add_row(OP_POW, 7, 0, 1, 1, 1, ST_OK);                  // power zero
        add_row(OP_MUL, '1, '1, 1, 1, 1, ST_OK);
        add_row(OP_DIV, 100, 7, 1, 1, 14, ST_OK);
        add_row(OP_POW, 3, 5, 1, 1, 243, ST_OK);
        // all-ones plus all-ones over 16 words, with a 17th pair dropped
        for (int i = 0; i < WORDS; i++)
            add_row(OP_MUL, '1, '1, 0, 0, 0, ST_OK);
        add_row(OP_ADD, 0, 0, 1, 1, 32'hFFFF_FFFE, ST_OK);

        foreach (rows[i]) begin
            r = rows[i];
            send_item(r.op, r.a, r.b, r.last);
            if (r.chk && (first_word_pred !== r.w0 || status_pred !== r.st)) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: expected word %h st%0d, model %h st%0d",
                             i, r.w0, r.st, first_word_pred, status_pred);
            end
        end

        while (items_sent < 330)
            random_operation();

        s_valid = 1'b0;
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/miau_pkg.sv
rtl/miau_datapath.sv
rtl/miau_ctrl.sv
rtl/multiword_integer_arithmetic_unit_top.sv
rtl/miau_checker.sv
verif/tb_multiword_integer_arithmetic_unit_top.sv
